// ----- hw/rtl/dfc_pkg.sv -----
// Shared types and constants for the display fit and crop geometry block.
// No dependencies; imported by every RTL module of the block.
package dfc_pkg;

  localparam int DIM_BITS       = 12;
  localparam int OFF_BITS       = DIM_BITS + 1;
  localparam int ZOOM_BITS      = 16;
  localparam int ZOOM_FRAC_BITS = 8;
  localparam int ZOOM_RESET     = 256;
  localparam int ZOOM_ONE       = 1 << ZOOM_FRAC_BITS;
  // ratio terms after zoom: numerator grows by the integer zoom bits,
  // denominator by the fraction bits
  localparam int RATIO_BITS     = (DIM_BITS + ZOOM_BITS - ZOOM_FRAC_BITS) >
                                  (DIM_BITS + ZOOM_FRAC_BITS) ?
                                  (DIM_BITS + ZOOM_BITS - ZOOM_FRAC_BITS) :
                                  (DIM_BITS + ZOOM_FRAC_BITS);
  localparam int DIV_BITS       = DIM_BITS + RATIO_BITS;

  typedef struct packed {
    logic [DIM_BITS-1:0] source_width;
    logic [DIM_BITS-1:0] source_height;
    logic [DIM_BITS-1:0] display_width;
    logic [DIM_BITS-1:0] display_height;
    logic [DIM_BITS-1:0] display_x_offset;
    logic [DIM_BITS-1:0] display_y_offset;
  } dfc_req_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] crop_x_start;
    logic [DIM_BITS-1:0] crop_y_start;
    logic [DIM_BITS-1:0] crop_width;
    logic [DIM_BITS-1:0] crop_height;
    logic [DIM_BITS-1:0] scaled_width;
    logic [DIM_BITS-1:0] scaled_height;
    logic [OFF_BITS-1:0] left_offset;
    logic [OFF_BITS-1:0] top_offset;
  } dfc_res_t;

endpackage

// ----- hw/rtl/dfc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, DIV_BITS stages.
// Depends on dfc_pkg. A zero divisor yields a zero quotient.
module dfc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [dfc_pkg::DIV_BITS-1:0] num,
  input  logic [dfc_pkg::DIV_BITS-1:0] den,
  output logic                         out_valid,
  output logic [dfc_pkg::DIV_BITS-1:0] quo
);
  import dfc_pkg::*;

  logic                v   [1:DIV_BITS];
  logic [DIV_BITS-1:0] rem [1:DIV_BITS];
  logic [DIV_BITS-1:0] nr  [1:DIV_BITS];
  logic [DIV_BITS-1:0] q   [1:DIV_BITS];
  logic [DIV_BITS-1:0] d   [1:DIV_BITS];

  for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
    logic                v_in;
    logic [DIV_BITS-1:0] r_in, n_in, q_in, d_in;
    logic [DIV_BITS:0]   trial;
    logic                fits;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign n_in = num;
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign v_in = v[s];
      assign r_in = rem[s];
      assign n_in = nr[s];
      assign q_in = q[s];
      assign d_in = d[s];
    end

    always_comb begin
      trial = {r_in, n_in[DIV_BITS-1]};
      fits  = trial >= {1'b0, d_in};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v_in;
      end
      rem[s+1] <= fits ? DIV_BITS'(trial - {1'b0, d_in}) : trial[DIV_BITS-1:0];
      nr[s+1]  <= {n_in[DIV_BITS-2:0], 1'b0};
      q[s+1]   <= {q_in[DIV_BITS-2:0], fits};
      d[s+1]   <= d_in;
    end
  end

  assign out_valid = v[DIV_BITS];
  assign quo       = (d[DIV_BITS] == '0) ? '0 : q[DIV_BITS];

endmodule

// ----- hw/rtl/display_fit_crop_geometry.sv -----
// Top level of the display fit and crop geometry block.
// Depends on dfc_pkg and dfc_div (five pipelined divider instances).
//
// Usage:
//   Request channel: drive request and pulse start. An item is taken at
//   every rising edge with start high and busy low; busy is tied low, so
//   one item may be taken every cycle.
//   Result channel: strobe is high for exactly one cycle with result; the
//   receiver must take it then, there is no back-pressure.
//   Config: cfg_we with cfg_wdata writes the Q8.8 zoom register; write it
//   only while no items are in flight.
// Pipeline: two entry stages (cross products, axis select), three 32-stage
//   divider steps in series (zoom divide, scaled size divide, crop divide),
//   a register stage after each of the first two divider steps (zoomed ratio,
//   rounding and crop numerators) and one output stage.
// Throughput: one item per cycle, set by the fully pipelined dividers.
// Reset: rst (synchronous) clears all valid bits and sets zoom to 1.0;
//   items in flight are dropped.
module display_fit_crop_geometry (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  dfc_pkg::dfc_req_t              request,
  input  logic                           cfg_we,
  input  logic [dfc_pkg::ZOOM_BITS-1:0]  cfg_wdata,
  output logic                           strobe,
  output dfc_pkg::dfc_res_t              result
);
  import dfc_pkg::*;

  localparam int DLY = DIV_BITS;

  typedef struct packed {
    dfc_req_t              req;
    logic [DIM_BITS-1:0]   mul;
    logic [DIM_BITS-1:0]   dv;
    logic [RATIO_BITS-1:0] mz;
    logic                  zbig;
  } hold1_t;

  typedef struct packed {
    dfc_req_t            req;
    logic [DIM_BITS-1:0] ow;
    logic [DIM_BITS-1:0] oh;
    logic                ovw;
    logic                ovh;
  } hold3_t;

  assign busy = 1'b0;

  // zoom register, zero treated as the smallest code
  logic [ZOOM_BITS-1:0] zoom;
  logic [ZOOM_BITS-1:0] zq;
  always_ff @(posedge clk) begin
    if (rst) begin
      zoom <= ZOOM_BITS'(ZOOM_RESET);
    end else if (cfg_we) begin
      zoom <= cfg_wdata;
    end
  end
  assign zq = (zoom == '0) ? ZOOM_BITS'(1) : zoom;

  // stage 1: cross products for the limiting axis test
  logic                  v1;
  dfc_req_t              r1;
  logic [2*DIM_BITS-1:0] p_dw_sh, p_dh_sw;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
    r1      <= request;
    p_dw_sh <= {{DIM_BITS{1'b0}}, request.display_width}  *
               {{DIM_BITS{1'b0}}, request.source_height};
    p_dh_sw <= {{DIM_BITS{1'b0}}, request.display_height} *
               {{DIM_BITS{1'b0}}, request.source_width};
  end

  // stage 2: pick ratio mul/dv
  logic                v2;
  dfc_req_t            r2;
  logic [DIM_BITS-1:0] mul2, dv2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    r2 <= r1;
    if (p_dw_sh > p_dh_sw) begin
      mul2 <= r1.display_height;
      dv2  <= r1.source_height;
    end else begin
      mul2 <= r1.display_width;
      dv2  <= r1.source_width;
    end
  end

  // zoom below 1: dv = (dv << F) / z; at or above 1: mul = (mul * z) >> F
  logic                v_d1;
  logic [DIV_BITS-1:0] quo1;
  dfc_div u_div_zoom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (DIV_BITS'({dv2, {ZOOM_FRAC_BITS{1'b0}}})),
    .den       (DIV_BITS'(zq)),
    .out_valid (v_d1),
    .quo       (quo1)
  );

  logic [DIM_BITS+ZOOM_BITS-1:0] mz_full;
  assign mz_full = {{ZOOM_BITS{1'b0}}, mul2} * {{DIM_BITS{1'b0}}, zq};

  hold1_t d1 [0:DLY-1];
  always_ff @(posedge clk) begin
    d1[0].req  <= r2;
    d1[0].mul  <= mul2;
    d1[0].dv   <= dv2;
    d1[0].mz   <= RATIO_BITS'(mz_full >> ZOOM_FRAC_BITS);
    d1[0].zbig <= zq >= ZOOM_BITS'(ZOOM_ONE);
    for (int k = 1; k < DLY; k++) begin
      d1[k] <= d1[k-1];
    end
  end

  // stage 3: zoomed ratio, numerators of the scaled sizes
  logic                  v3;
  dfc_req_t              r3;
  logic [RATIO_BITS-1:0] mulf, dvf, dvf3;
  logic [DIV_BITS-1:0]   numw3, numh3;
  always_comb begin
    if (d1[DLY-1].zbig) begin
      mulf = d1[DLY-1].mz;
      dvf  = RATIO_BITS'(d1[DLY-1].dv);
    end else begin
      mulf = RATIO_BITS'(d1[DLY-1].mul);
      dvf  = quo1[RATIO_BITS-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v_d1;
    end
    r3    <= d1[DLY-1].req;
    dvf3  <= dvf;
    numw3 <= DIV_BITS'(d1[DLY-1].req.source_width)  * DIV_BITS'(mulf);
    numh3 <= DIV_BITS'(d1[DLY-1].req.source_height) * DIV_BITS'(mulf);
  end

  logic                v_d2, v_d2h;
  logic [DIV_BITS-1:0] quo_w, quo_h;
  dfc_div u_div_sw (
    .clk (clk), .rst (rst), .in_valid (v3), .num (numw3),
    .den (DIV_BITS'(dvf3)), .out_valid (v_d2), .quo (quo_w)
  );
  dfc_div u_div_sh (
    .clk (clk), .rst (rst), .in_valid (v3), .num (numh3),
    .den (DIV_BITS'(dvf3)), .out_valid (v_d2h), .quo (quo_h)
  );

  dfc_req_t d2 [0:DLY-1];
  always_ff @(posedge clk) begin
    d2[0] <= r3;
    for (int k = 1; k < DLY; k++) begin
      d2[k] <= d2[k-1];
    end
  end

  // stage 4: round scaled sizes, overflow tests, crop numerators
  logic                  v4, ovw4, ovh4;
  dfc_req_t              r4;
  logic [DIV_BITS-1:0]   ow_c, oh_c, ow4, oh4;
  logic [2*DIM_BITS-1:0] nw4, nh4;
  assign ow_c = quo_w & ~DIV_BITS'(4'hF);
  assign oh_c = quo_h & ~DIV_BITS'(1);
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v_d2 & v_d2h;
    end
    r4   <= d2[DLY-1];
    ow4  <= ow_c;
    oh4  <= oh_c;
    ovw4 <= ow_c > DIV_BITS'(d2[DLY-1].display_width);
    ovh4 <= oh_c > DIV_BITS'(d2[DLY-1].display_height);
    nw4  <= {{DIM_BITS{1'b0}}, d2[DLY-1].source_width}  *
            {{DIM_BITS{1'b0}}, d2[DLY-1].display_width};
    nh4  <= {{DIM_BITS{1'b0}}, d2[DLY-1].source_height} *
            {{DIM_BITS{1'b0}}, d2[DLY-1].display_height};
  end

  logic                v_d3, v_d3h;
  logic [DIV_BITS-1:0] quo_cw, quo_ch;
  dfc_div u_div_cw (
    .clk (clk), .rst (rst), .in_valid (v4), .num (DIV_BITS'(nw4)),
    .den (ow4), .out_valid (v_d3), .quo (quo_cw)
  );
  dfc_div u_div_ch (
    .clk (clk), .rst (rst), .in_valid (v4), .num (DIV_BITS'(nh4)),
    .den (oh4), .out_valid (v_d3h), .quo (quo_ch)
  );

  hold3_t d3 [0:DLY-1];
  always_ff @(posedge clk) begin
    d3[0].req <= r4;
    d3[0].ow  <= ow4[DIM_BITS-1:0];
    d3[0].oh  <= oh4[DIM_BITS-1:0];
    d3[0].ovw <= ovw4;
    d3[0].ovh <= ovh4;
    for (int k = 1; k < DLY; k++) begin
      d3[k] <= d3[k-1];
    end
  end

  // stage 5: crop window, clamp, centering offsets
  hold3_t              h;
  dfc_res_t            res_next;
  logic [DIM_BITS-1:0] cw, ch, owf, ohf;
  assign h = d3[DLY-1];
  always_comb begin
    res_next = '0;
    if (h.ovw) begin
      cw                    = quo_cw[DIM_BITS-1:0] & ~DIM_BITS'(1);
      res_next.crop_x_start = ((h.req.source_width - cw) >> 1) & ~DIM_BITS'(1);
      owf                   = h.req.display_width & ~DIM_BITS'(4'hF);
    end else begin
      cw  = h.req.source_width;
      owf = h.ow;
    end
    if (h.ovh) begin
      ch                    = quo_ch[DIM_BITS-1:0] & ~DIM_BITS'(1);
      res_next.crop_y_start = ((h.req.source_height - ch) >> 1) & ~DIM_BITS'(1);
      ohf                   = h.req.display_height & ~DIM_BITS'(1);
    end else begin
      ch  = h.req.source_height;
      ohf = h.oh;
    end
    res_next.crop_width    = cw;
    res_next.crop_height   = ch;
    res_next.scaled_width  = owf;
    res_next.scaled_height = ohf;
    res_next.left_offset   = (OFF_BITS'(h.req.display_x_offset) +
                              OFF_BITS'((h.req.display_width - owf) >> 1)) &
                             ~OFF_BITS'(1);
    res_next.top_offset    = (OFF_BITS'(h.req.display_y_offset) +
                              OFF_BITS'((h.req.display_height - ohf) >> 1)) &
                             ~OFF_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v_d3 & v_d3h;
    end
    result <= res_next;
  end

endmodule

// ----- hw/rtl/dfc_checker.sv -----
// Port-level checker for display_fit_crop_geometry, with its bind.
// Depends on dfc_pkg and the top level's ports.
module dfc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input dfc_pkg::dfc_res_t result
);
  import dfc_pkg::*;

  // each strobe must trace back to an item accepted with start high and busy low
  a_latency: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy && !rst, 101))
    else $error("result without matching item");

  a_width_align: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.scaled_width[3:0] == 4'h0 && result.scaled_height[0] == 1'b0))
    else $error("scaled size misaligned");

  a_even: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.crop_x_start[0] == 1'b0 && result.crop_y_start[0] == 1'b0 &&
                result.left_offset[0] == 1'b0 && result.top_offset[0] == 1'b0))
    else $error("odd crop start or offset");

  a_no_strobe_after_reset: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("strobe right after reset");

endmodule

bind display_fit_crop_geometry dfc_checker u_dfc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for display_fit_crop_geometry: sizes, offsets, zoom.
// Depends on dfc_pkg and the RTL top level; predicts each layout in SystemVerilog.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dfc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dfc_req_t request = '0;
  logic cfg_we = 1'b0;
  logic [ZOOM_BITS-1:0] cfg_wdata = '0;
  logic strobe;
  dfc_res_t result;

  // zoom setting the predictor tracks; mirrors the block's register
  logic [ZOOM_BITS-1:0] zoom_now;
  dfc_res_t layout_q[$];
  int errors = 0;
  int seen = 0;

  // drain wait; long enough to cover the full pipeline of the block
  localparam int DRAIN_CYCLES = 120;

  display_fit_crop_geometry u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe), .result(result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Layout predictor: exact integer math, wide enough that nothing wraps.
  function automatic dfc_res_t predict_layout(dfc_req_t r, logic [ZOOM_BITS-1:0] zr);
    logic [63:0] sw, sh, dw, dh, xo, yo, z, mul, dv, ow, oh, cw, ch, cx, cy;
    dfc_res_t o;
    sw = 64'(r.source_width);  sh = 64'(r.source_height);
    dw = 64'(r.display_width); dh = 64'(r.display_height);
    xo = 64'(r.display_x_offset); yo = 64'(r.display_y_offset);
    z = (zr == '0) ? 64'd1 : 64'(zr);
    cw = sw; ch = sh; cx = 64'd0; cy = 64'd0;
    // limiting axis picks the nominal ratio
    if (dw * sh > dh * sw) begin
      mul = dh; dv = sh;
    end else begin
      mul = dw; dv = sw;
    end
    if (z >= 64'(ZOOM_ONE)) mul = (mul * z) >> ZOOM_FRAC_BITS;
    else dv = (dv << ZOOM_FRAC_BITS) / z;
    // divide by zero yields 0
    ow = (dv != 64'd0) ? ((sw * mul) / dv) & ~64'hF : 64'd0;
    oh = (dv != 64'd0) ? ((sh * mul) / dv) & ~64'h1 : 64'd0;
    // overflowing axis: centered even crop, clamp to window
    if (ow > dw) begin
      cw = (sw * dw / ow) & ~64'h1;
      cx = ((sw - cw) / 2) & ~64'h1;
      ow = dw & ~64'hF;
    end
    if (oh > dh) begin
      ch = (sh * dh / oh) & ~64'h1;
      cy = ((sh - ch) / 2) & ~64'h1;
      oh = dh & ~64'h1;
    end
    o.crop_x_start  = cx[DIM_BITS-1:0];
    o.crop_y_start  = cy[DIM_BITS-1:0];
    o.crop_width    = cw[DIM_BITS-1:0];
    o.crop_height   = ch[DIM_BITS-1:0];
    o.scaled_width  = ow[DIM_BITS-1:0];
    o.scaled_height = oh[DIM_BITS-1:0];
    o.left_offset   = OFF_BITS'((xo + (dw - ow) / 2) & ~64'h1);
    o.top_offset    = OFF_BITS'((yo + (dh - oh) / 2) & ~64'h1);
    return o;
  endfunction

  // Result checker: one strobe = one item, compared to the oldest prediction.
  always @(posedge clk) begin
    dfc_res_t want;
    if (!rst && strobe) begin
      if (layout_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        want = layout_q.pop_front();
        seen++;
        if (want.crop_x_start !== result.crop_x_start)
          $display("%0t: crop_x_start exp %0d got %0d", $time, want.crop_x_start,
                   result.crop_x_start);
        if (want.crop_y_start !== result.crop_y_start)
          $display("%0t: crop_y_start exp %0d got %0d", $time, want.crop_y_start,
                   result.crop_y_start);
        if (want.crop_width !== result.crop_width)
          $display("%0t: crop_width exp %0d got %0d", $time, want.crop_width,
                   result.crop_width);
        if (want.crop_height !== result.crop_height)
          $display("%0t: crop_height exp %0d got %0d", $time, want.crop_height,
                   result.crop_height);
        if (want.scaled_width !== result.scaled_width)
          $display("%0t: scaled_width exp %0d got %0d", $time, want.scaled_width,
                   result.scaled_width);
        if (want.scaled_height !== result.scaled_height)
          $display("%0t: scaled_height exp %0d got %0d", $time, want.scaled_height,
                   result.scaled_height);
        if (want.left_offset !== result.left_offset)
          $display("%0t: left_offset exp %0d got %0d", $time, want.left_offset,
                   result.left_offset);
        if (want.top_offset !== result.top_offset)
          $display("%0t: top_offset exp %0d got %0d", $time, want.top_offset,
                   result.top_offset);
        if (want !== result) errors++;
      end
    end
  end

  // Drop start after the last item of a burst; call at a falling edge.
  task automatic end_burst();
    start <= 1'b0;
  endtask

  // Send one item; an idle gap of random length first when requested.
  // start stays high after the item so the next one can follow with no gap.
  task automatic send_item(dfc_req_t r, bit gaps = 1);
    int idle;
    idle = gaps ? $urandom_range(0, 10) : 0;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    request <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    layout_q.push_back(predict_layout(r, zoom_now));
    @(negedge clk);
  endtask

  // Wait for all results, then for the pipeline to be quiet, then write zoom.
  task automatic set_zoom(logic [ZOOM_BITS-1:0] z);
    end_burst();
    wait (layout_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wdata <= z;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    zoom_now = z;
  endtask

  function automatic dfc_req_t make_req(int sw, int sh, int dw, int dh, int xo, int yo);
    dfc_req_t r;
    r.source_width = DIM_BITS'(sw);  r.source_height = DIM_BITS'(sh);
    r.display_width = DIM_BITS'(dw); r.display_height = DIM_BITS'(dh);
    r.display_x_offset = DIM_BITS'(xo); r.display_y_offset = DIM_BITS'(yo);
    return r;
  endfunction

  // Random request; mostly raw random fields, sometimes a zero size or in-range sizes.
  function automatic dfc_req_t rand_req();
    dfc_req_t r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(dfc_req_t)-1:0];
    case ($urandom_range(0, 9))
      0: r.source_width = '0;
      1: r.display_height = '0;
      2: begin
        r.source_width = DIM_BITS'($urandom_range(16, 1920));
        r.source_height = DIM_BITS'($urandom_range(16, 1080));
        r.display_width = DIM_BITS'($urandom_range(16, 1280));
        r.display_height = DIM_BITS'($urandom_range(16, 1024));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Field extremes, zero corners and both axis choices, no gaps.
  task automatic test_directed();
    send_item(make_req(1, 1, 1, 1, 0, 0), 0);
    send_item(make_req(4095, 4095, 4095, 4095, 4095, 4095), 0);
    send_item(make_req(1920, 1080, 800, 480, 0, 0), 0);
    send_item(make_req(640, 480, 1280, 720, 100, 50), 0);
    send_item(make_req(0, 0, 800, 600, 10, 10), 0);      // zero divisor
    send_item(make_req(1280, 1024, 0, 600, 0, 0), 0);    // zero window width
    send_item(make_req(1280, 1024, 800, 0, 0, 0), 0);    // zero window height
    send_item(make_req(0, 1024, 800, 600, 0, 0), 0);
    send_item(make_req(1024, 0, 800, 600, 0, 0), 0);
    send_item(make_req(4095, 1, 1, 4095, 4095, 0), 0);
    send_item(make_req(1, 4095, 4095, 1, 0, 4095), 0);
    send_item(make_req(2730, 1365, 1365, 2730, 2730, 1365), 0);
  endtask

  // Two directed items and three random ones at each zoom, including the extremes and zero.
  task automatic test_zoom_sweep();
    logic [ZOOM_BITS-1:0] zl[7] = '{16'd0, 16'd1, 16'd128, 16'd255, 16'd512,
                                    16'd65535, 16'd256};
    foreach (zl[i]) begin
      set_zoom(zl[i]);
      send_item(make_req(1920, 1080, 800, 480, 0, 0));
      send_item(make_req(640, 480, 1280, 720, 7, 9));
      repeat (3) send_item(rand_req());
    end
  endtask

  // Bulk random traffic in zoom phases (first at 1.0, then random); one full pause mid-way.
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      set_zoom((ph == 0) ? 16'd256 : 16'($urandom_range(0, 65535)));
      for (int i = 0; i < 100; i++) begin
        // back-to-back bursts alternate with gapped stretches
        send_item(rand_req(), ph[0]);
        if (ph == 2 && i == 50) begin
          end_burst();
          wait (layout_q.size() == 0);
        end
      end
    end
  endtask

  initial begin
    zoom_now = ZOOM_BITS'(ZOOM_RESET);
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zoom_sweep();
    test_random();
    end_burst();
    wait (layout_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
